/* rtl/sfs_pkg.sv */
// Package for the HEVC scaling factor store: sizes, codes, payload and request types.
// Also holds the default scaling tables, the scan-position helper and the DC address map.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sfs_pkg;

  localparam int LIST_ENTRIES = 64;
  localparam int LIST_LEN_4X4 = 16;
  localparam int NUM_MATRICES = 6;
  localparam int NUM_MATRICES_32 = 2;
  localparam int CNT_W = 7;
  localparam int ADDR_W = 10;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int DC_ADDR_W = 3;
  localparam int DC_DEPTH = 1 << DC_ADDR_W;
  localparam logic [7:0] FLAT_VALUE = 8'd16;

  localparam logic [1:0] SIZE_4X4 = 2'd0;
  localparam logic [1:0] SIZE_8X8 = 2'd1;
  localparam logic [1:0] SIZE_16X16 = 2'd2;
  localparam logic [1:0] SIZE_32X32 = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD_COEF = 2'd0,
    OP_LOAD_DC   = 2'd1,
    OP_PREDICT   = 2'd2,
    OP_LOOKUP    = 2'd3
  } sfs_op_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DECODE = 2'd1,
    ST_PRED   = 2'd2,
    ST_EMIT   = 2'd3
  } sfs_state_e;

  typedef struct packed {
    sfs_op_e     op;
    logic [1:0]  size_class;
    logic [2:0]  matrix_sel;
    logic [5:0]  coef_index;
    logic [7:0]  coef_value;
    logic [2:0]  ref_delta;
    logic [1:0]  colour_component;
    logic        is_intra;
    logic [4:0]  pos_x;
    logic [4:0]  pos_y;
  } sfs_in_t;

  typedef struct packed {
    logic [7:0] scale_factor;
    logic       bad_request;
  } sfs_out_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [7:0]           wdata;
    logic                 re;
    logic [ADDR_W-1:0]    raddr;
    logic                 dc_we;
    logic [DC_ADDR_W-1:0] dc_waddr;
    logic [7:0]           dc_wdata;
    logic                 dc_re;
    logic [DC_ADDR_W-1:0] dc_raddr;
  } sfs_mem_req_t;

  localparam logic [7:0] DFLT_INTRA [64] = '{
    8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16,
    8'd16, 8'd16, 8'd17, 8'd16, 8'd17, 8'd16, 8'd17, 8'd18,
    8'd17, 8'd18, 8'd18, 8'd17, 8'd18, 8'd21, 8'd19, 8'd20,
    8'd21, 8'd20, 8'd19, 8'd21, 8'd24, 8'd22, 8'd22, 8'd24,
    8'd24, 8'd22, 8'd22, 8'd24, 8'd25, 8'd25, 8'd27, 8'd30,
    8'd27, 8'd25, 8'd25, 8'd29, 8'd31, 8'd35, 8'd35, 8'd31,
    8'd29, 8'd36, 8'd41, 8'd44, 8'd41, 8'd36, 8'd47, 8'd54,
    8'd54, 8'd47, 8'd65, 8'd70, 8'd65, 8'd88, 8'd88, 8'd115
  };

  localparam logic [7:0] DFLT_INTER [64] = '{
    8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16,
    8'd16, 8'd16, 8'd17, 8'd17, 8'd17, 8'd17, 8'd17, 8'd18,
    8'd18, 8'd18, 8'd18, 8'd18, 8'd18, 8'd20, 8'd20, 8'd20,
    8'd20, 8'd20, 8'd20, 8'd20, 8'd24, 8'd24, 8'd24, 8'd24,
    8'd24, 8'd24, 8'd24, 8'd24, 8'd25, 8'd25, 8'd25, 8'd25,
    8'd25, 8'd25, 8'd25, 8'd28, 8'd28, 8'd28, 8'd28, 8'd28,
    8'd28, 8'd33, 8'd33, 8'd33, 8'd33, 8'd33, 8'd41, 8'd41,
    8'd41, 8'd41, 8'd54, 8'd54, 8'd54, 8'd71, 8'd71, 8'd91
  };

  function automatic logic [7:0] sfs_default_entry(input logic [1:0] size,
                                                   input logic [2:0] mtx,
                                                   input logic [5:0] idx);
    logic intra_tab;
    intra_tab = (size == SIZE_32X32) ? (mtx < 3'd1) : (mtx < 3'd3);
    if (size == SIZE_4X4) begin
      return FLAT_VALUE;
    end else if (intra_tab) begin
      return DFLT_INTRA[idx];
    end else begin
      return DFLT_INTER[idx];
    end
  endfunction

  // Inverse up-right diagonal scan position in a 4x4 or 8x8 block.
  function automatic logic [5:0] sfs_diag_idx(input logic [2:0] x,
                                              input logic [2:0] y,
                                              input logic big);
    logic [7:0] n;
    logic [7:0] d;
    logic [7:0] prod;
    logic [7:0] preceding;
    logic [7:0] low;
    n = big ? 8'd8 : 8'd4;
    d = 8'(x) + 8'(y);
    if (d < n) begin
      prod = d * (d + 8'd1);
      preceding = prod >> 1;
      low = 8'(x);
    end else begin
      prod = (n + n - d - 8'd1) * (n + n - d);
      preceding = n * n - (prod >> 1);
      low = 8'(x) - (d - (n - 8'd1));
    end
    return 6'(preceding + low);
  endfunction

  function automatic logic [DC_ADDR_W-1:0] sfs_dc_addr(input logic [1:0] size,
                                                      input logic [2:0] mtx);
    if (size == SIZE_32X32) begin
      return DC_ADDR_W'(4'(NUM_MATRICES) + 4'(mtx));
    end else begin
      return DC_ADDR_W'(mtx);
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/sfs_agen.sv */
// Address unit: list store address from size class, matrix and list index.
// Shared by loads, list prediction and lookups. Uses sfs_pkg.
`default_nettype none

module sfs_agen (
  input  logic [1:0]                 size_class_i,
  input  logic [2:0]                 matrix_i,
  input  logic [5:0]                 index_i,
  output logic [sfs_pkg::ADDR_W-1:0] addr_o
);
  import sfs_pkg::*;

  localparam int SUM_W = ADDR_W + 2;
  localparam int BASE_8X8 = NUM_MATRICES * LIST_LEN_4X4;
  localparam int BASE_16X16 = BASE_8X8 + NUM_MATRICES * LIST_ENTRIES;
  localparam int BASE_32X32 = BASE_16X16 + NUM_MATRICES * LIST_ENTRIES;

  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] mtx_ofs;
  logic [SUM_W-1:0] sum;

  always_comb begin
    unique case (size_class_i)
      SIZE_4X4: begin
        base = '0;
        mtx_ofs = SUM_W'(matrix_i) * SUM_W'(LIST_LEN_4X4);
      end
      SIZE_8X8: begin
        base = SUM_W'(BASE_8X8);
        mtx_ofs = SUM_W'(matrix_i) * SUM_W'(LIST_ENTRIES);
      end
      SIZE_16X16: begin
        base = SUM_W'(BASE_16X16);
        mtx_ofs = SUM_W'(matrix_i) * SUM_W'(LIST_ENTRIES);
      end
      default: begin
        base = SUM_W'(BASE_32X32);
        mtx_ofs = SUM_W'(matrix_i) * SUM_W'(LIST_ENTRIES);
      end
    endcase
    sum = base + mtx_ofs + SUM_W'(index_i);
  end

  assign addr_o = sum[ADDR_W-1:0];

endmodule

`default_nettype wire

/* rtl/sfs_store.sv */
// List coefficient memory and DC value registers, both with registered read data.
// Driven by one request struct from the sequencer. Uses sfs_pkg.
`default_nettype none

module sfs_store (
  input  logic                  clk_i,
  input  sfs_pkg::sfs_mem_req_t req_i,
  output logic [7:0]            coef_rdata_o,
  output logic [7:0]            dc_rdata_o
);
  import sfs_pkg::*;

  logic [7:0] coef_mem [MEM_DEPTH];
  logic [7:0] dc_mem [DC_DEPTH];
  logic [7:0] coef_rdata_q;
  logic [7:0] dc_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      coef_mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      coef_rdata_q <= coef_mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.dc_we) begin
      dc_mem[req_i.dc_waddr] <= req_i.dc_wdata;
    end
    if (req_i.dc_re) begin
      dc_rdata_q <= dc_mem[req_i.dc_raddr];
    end
  end

  assign coef_rdata_o = coef_rdata_q;
  assign dc_rdata_o = dc_rdata_q;

endmodule

`default_nettype wire

/* rtl/sfs_ctrl.sv */
// Sequencer: request checks, list fill and copy loop, lookup and result forming.
// Drives the shared address unit sfs_agen and the store requests. Uses sfs_pkg.
`default_nettype none

module sfs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sfs_pkg::sfs_in_t      in_data_i,
  input  logic                  use_dflt_i,
  input  logic                  res_ready_i,
  output logic                  res_load_o,
  output sfs_pkg::sfs_out_t     res_data_o,
  output sfs_pkg::sfs_mem_req_t mem_req_o,
  input  logic [7:0]            coef_rdata_i,
  input  logic [7:0]            dc_rdata_i
);
  import sfs_pkg::*;

  sfs_state_e        state_q, state_d;
  sfs_in_t           item_q, item_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] addr_q;

  logic [1:0]        s;
  logic [2:0]        msel;
  logic [2:0]        delta;
  logic [1:0]        cc;
  logic [4:0]        px, py;
  logic              mat_ok;
  logic [CNT_W-1:0]  len;
  logic [2:0]        ref_m;
  logic              copy_mode;
  logic [ADDR_W-1:0] copy_ofs;
  logic              oob;
  logic [2:0]        dx, dy;
  logic [2:0]        lk_m;
  logic [5:0]        lk_idx;
  logic              lk_bad;
  logic              dc_pos;
  logic              item_bad;
  logic [2:0]        agen_m;
  logic [5:0]        agen_i;
  logic [ADDR_W-1:0] agen_addr;

  assign s = item_q.size_class;
  assign msel = item_q.matrix_sel;
  assign delta = item_q.ref_delta;
  assign cc = item_q.colour_component;
  assign px = item_q.pos_x;
  assign py = item_q.pos_y;

  always_comb begin
    mat_ok = (s == SIZE_32X32) ? (msel < 3'(NUM_MATRICES_32)) : (msel < 3'(NUM_MATRICES));
    len = (s == SIZE_4X4) ? CNT_W'(LIST_LEN_4X4) : CNT_W'(LIST_ENTRIES);
    ref_m = msel - delta;
    copy_mode = (delta != 3'd0);
    copy_ofs = (s == SIZE_4X4) ? ADDR_W'(delta) * ADDR_W'(LIST_LEN_4X4)
                               : ADDR_W'(delta) * ADDR_W'(LIST_ENTRIES);

    unique case (s)
      SIZE_4X4: begin
        oob = (px[4:2] != 3'd0) || (py[4:2] != 3'd0);
        dx = px[2:0];
        dy = py[2:0];
      end
      SIZE_8X8: begin
        oob = (px[4:3] != 2'd0) || (py[4:3] != 2'd0);
        dx = px[2:0];
        dy = py[2:0];
      end
      SIZE_16X16: begin
        oob = px[4] || py[4];
        dx = px[3:1];
        dy = py[3:1];
      end
      default: begin
        oob = 1'b0;
        dx = px[4:2];
        dy = py[4:2];
      end
    endcase

    if (s == SIZE_32X32) begin
      lk_m = item_q.is_intra ? 3'd0 : 3'd1;
    end else begin
      lk_m = (item_q.is_intra ? 3'd0 : 3'd3) + 3'(cc);
    end
    lk_idx = (s == SIZE_4X4) ? sfs_diag_idx({1'b0, px[1:0]}, {1'b0, py[1:0]}, 1'b0)
                             : sfs_diag_idx(dx, dy, 1'b1);
    lk_bad = (cc == 2'd3) || ((s == SIZE_32X32) && (cc != 2'd0)) || oob ||
             (CNT_W'(lk_idx) >= len);
    dc_pos = (s == SIZE_16X16 || s == SIZE_32X32) && (px == 5'd0) && (py == 5'd0);

    unique case (item_q.op)
      OP_LOAD_COEF: item_bad = !mat_ok || (CNT_W'(item_q.coef_index) >= len);
      OP_LOAD_DC:   item_bad = (s == SIZE_4X4) || (s == SIZE_8X8) || !mat_ok;
      OP_PREDICT:   item_bad = !mat_ok || (delta > msel);
      default:      item_bad = lk_bad;
    endcase

    agen_m = msel;
    agen_i = item_q.coef_index;
    if (state_q == ST_PRED) begin
      agen_m = copy_mode ? ref_m : msel;
      agen_i = cnt_q[5:0];
    end else if (item_q.op == OP_LOOKUP) begin
      agen_m = lk_m;
      agen_i = lk_idx;
    end
  end

  sfs_agen u_agen (
    .size_class_i (s),
    .matrix_i     (agen_m),
    .index_i      (agen_i),
    .addr_o       (agen_addr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    addr_q <= agen_addr;
  end

  always_comb begin
    state_d = state_q;
    item_d = item_q;
    cnt_d = cnt_q;
    in_stall_o = 1'b1;
    res_load_o = 1'b0;
    res_data_o = '0;
    mem_req_o = '0;
    mem_req_o.waddr = agen_addr;
    mem_req_o.raddr = agen_addr;
    mem_req_o.wdata = item_q.coef_value;
    mem_req_o.dc_waddr = sfs_dc_addr(s, msel);
    mem_req_o.dc_wdata = item_q.coef_value;
    mem_req_o.dc_raddr = sfs_dc_addr(s, lk_m);

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          item_d = in_data_i;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (item_bad) begin
          state_d = ST_EMIT;
        end else begin
          unique case (item_q.op)
            OP_LOAD_COEF: begin
              mem_req_o.we = 1'b1;
              state_d = ST_IDLE;
            end
            OP_LOAD_DC: begin
              mem_req_o.dc_we = 1'b1;
              state_d = ST_IDLE;
            end
            OP_PREDICT: begin
              cnt_d = '0;
              state_d = ST_PRED;
            end
            default: begin
              mem_req_o.re = 1'b1;
              mem_req_o.dc_re = 1'b1;
              state_d = ST_EMIT;
            end
          endcase
        end
      end

      ST_PRED: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (!copy_mode) begin
          mem_req_o.we = 1'b1;
          mem_req_o.wdata = sfs_default_entry(s, msel, cnt_q[5:0]);
          mem_req_o.dc_we = (cnt_q == '0) && (s == SIZE_16X16 || s == SIZE_32X32);
          mem_req_o.dc_wdata = FLAT_VALUE;
          if (cnt_q == len - CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end else begin
          mem_req_o.re = (cnt_q < len);
          mem_req_o.we = (cnt_q != '0);
          mem_req_o.waddr = addr_q + copy_ofs;
          mem_req_o.wdata = coef_rdata_i;
          mem_req_o.dc_re = (cnt_q == '0);
          mem_req_o.dc_raddr = sfs_dc_addr(s, ref_m);
          mem_req_o.dc_we = (cnt_q == CNT_W'(1)) && (s == SIZE_16X16 || s == SIZE_32X32);
          mem_req_o.dc_wdata = dc_rdata_i;
          if (cnt_q == len) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        if (item_bad) begin
          res_data_o.bad_request = 1'b1;
        end else if (dc_pos) begin
          res_data_o.scale_factor = use_dflt_i ? FLAT_VALUE : dc_rdata_i;
        end else begin
          res_data_o.scale_factor = use_dflt_i ? sfs_default_entry(s, lk_m, lk_idx)
                                               : coef_rdata_i;
        end
        if (res_ready_i) begin
          res_load_o = 1'b1;
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_DECODE))
    else $error("accepted item not decoded next cycle");

  a_pred_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRED) |-> (cnt_q <= len))
    else $error("list prediction ran past list length");

  a_copy_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRED && mem_req_o.we && mem_req_o.re) |->
      (mem_req_o.waddr != mem_req_o.raddr))
    else $error("list copy overwrites its source");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.we || mem_req_o.dc_we) |-> (state_q == ST_DECODE || state_q == ST_PRED))
    else $error("store write outside decode or prediction");

endmodule

`default_nettype wire

/* rtl/hevc_scaling_factor_store.sv */
// Top level of the HEVC scaling factor store: config register, output register,
// sequencer and list store. Uses sfs_pkg, sfs_ctrl, sfs_store.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   in_data_i (sfs_in_t)
//   out       output     out_valid_o / out_stall_i out_data_o (sfs_out_t)
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_wdata_i (use_default_lists)
//
// One item at a time: loads write in the decode state, lookups read there and pass
// their result on from the emit state, and list prediction fills or copies a list entry
// by entry, paced by the single write port of the coefficient memory.
// Reset sets control state only (default lists selected); list and DC contents are undefined until written.
// A result waits in the output register; the sequencer holds a finished result while
// the output register is full and stalled.
`default_nettype none

module hevc_scaling_factor_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sfs_pkg::sfs_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sfs_pkg::sfs_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_wdata_i
);
  import sfs_pkg::*;

  logic         use_dflt_q, use_dflt_d;
  logic         out_valid_q, out_valid_d;
  sfs_out_t     out_data_q, out_data_d;
  logic         res_ready;
  logic         res_load;
  sfs_out_t     res_data;
  sfs_mem_req_t mem_req;
  logic [7:0]   coef_rdata;
  logic [7:0]   dc_rdata;

  assign cfg_ready_o = 1'b1;
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    use_dflt_d = use_dflt_q;
    if (cfg_valid_i && cfg_ready_o) begin
      use_dflt_d = cfg_wdata_i;
    end
    out_valid_d = out_valid_q;
    out_data_d = out_data_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      out_data_d = res_data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_dflt_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      use_dflt_q <= use_dflt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  sfs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .use_dflt_i   (use_dflt_q),
    .res_ready_i  (res_ready),
    .res_load_o   (res_load),
    .res_data_o   (res_data),
    .mem_req_o    (mem_req),
    .coef_rdata_i (coef_rdata),
    .dc_rdata_i   (dc_rdata)
  );

  sfs_store u_store (
    .clk_i        (clk_i),
    .req_i        (mem_req),
    .coef_rdata_o (coef_rdata),
    .dc_rdata_o   (dc_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

endmodule

`default_nettype wire
